// ===== rtl/dti_pkg.sv =====
// Shared types, codes and constants of the decision tree inference block.
`timescale 1ns / 1ps

package dti_pkg;

    // Table sizes; the index widths of the request fields follow from them
    localparam int Nodes    = 256;
    localparam int Features = 64;
    localparam int NodeW    = $clog2(Nodes);
    localparam int FeatW    = $clog2(Features);

    // Default walk limit
    localparam int MaxDepth = 16;

    // Field widths
    localparam int ValW   = 32;
    localparam int SumW   = 48;
    localparam int StatW  = 2;
    localparam int StepsW = 5;
    localparam int ReqW   = 2;

    // Configuration port
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 32;

    // Register indexes
    localparam logic [CfgIdxW-1:0] CfgRoot  = 4'd0;
    localparam logic [CfgIdxW-1:0] CfgScale = 4'd1;

    // Register reset values
    localparam logic [NodeW-1:0]       RootReset  = '0;
    localparam logic signed [ValW-1:0] ScaleReset = 32'sd65536;

    // Request codes
    localparam logic [ReqW-1:0] ReqNode    = 2'd0;
    localparam logic [ReqW-1:0] ReqFeat    = 2'd1;
    localparam logic [ReqW-1:0] ReqPredict = 2'd2;

    // Status codes
    localparam logic [StatW-1:0] StatDone  = 2'd0;
    localparam logic [StatW-1:0] StatPred  = 2'd1;
    localparam logic [StatW-1:0] StatDepth = 2'd2;

    // Saturation bounds of the running sum
    localparam logic signed [SumW-1:0] SatMax = {1'b0, {(SumW-1){1'b1}}};
    localparam logic signed [SumW-1:0] SatMin = {1'b1, {(SumW-1){1'b0}}};

    // Rounding bias for Q32.32 to Q32.16
    localparam logic signed [2*ValW-1:0] RoundBias = 64'sd32768;

    // One node table entry
    typedef struct packed {
        logic                   is_leaf;
        logic [FeatW-1:0]       feature;
        logic signed [ValW-1:0] threshold;
        logic [NodeW-1:0]       left;
        logic [NodeW-1:0]       right;
        logic signed [ValW-1:0] value;
    } node_entry_t;

endpackage

// ===== rtl/dti_intf.sv =====
// Request, response and configuration channel interfaces.
`timescale 1ns / 1ps

interface dti_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [dti_pkg::ReqW-1:0]             req_type;
    logic [dti_pkg::NodeW-1:0]            node_index;
    logic                                 node_is_leaf;
    logic [dti_pkg::FeatW-1:0]            node_feature;
    logic signed [dti_pkg::ValW-1:0]      node_threshold;
    logic [dti_pkg::NodeW-1:0]            node_left;
    logic [dti_pkg::NodeW-1:0]            node_right;
    logic signed [dti_pkg::ValW-1:0]      node_value;
    logic [dti_pkg::FeatW-1:0]            feature_index;
    logic signed [dti_pkg::ValW-1:0]      feature_value;
    logic signed [dti_pkg::SumW-1:0]      prior_sum;

    modport source (
        output valid, req_type, node_index, node_is_leaf, node_feature, node_threshold,
               node_left, node_right, node_value, feature_index, feature_value, prior_sum,
        input  ready
    );
    modport sink (
        input  valid, req_type, node_index, node_is_leaf, node_feature, node_threshold,
               node_left, node_right, node_value, feature_index, feature_value, prior_sum,
        output ready
    );
endinterface

interface dti_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [dti_pkg::StatW-1:0]        status;
    logic signed [dti_pkg::ValW-1:0]  leaf_result;
    logic signed [dti_pkg::SumW-1:0]  prediction_sum;
    logic [dti_pkg::StepsW-1:0]       steps_taken;

    modport source (
        output valid, status, leaf_result, prediction_sum, steps_taken,
        input  ready
    );
    modport sink (
        input  valid, status, leaf_result, prediction_sum, steps_taken,
        output ready
    );
endinterface

interface dti_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dti_pkg::CfgIdxW-1:0]    index;
    logic [dti_pkg::CfgDataW-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/dti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dti_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/decision_tree_inference.sv =====
// Top level of the decision tree inference block: sequencer, tables and result path.
//
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    req_type, node and feature write fields, prior_sum
// rsp      out  valid/ready    status, leaf_result, prediction_sum, steps_taken
// cfg      in   valid/ready    index (0 root_node, 1 scale), data
//
// Node and feature writes: result goes via the emit state to the output register.
// Predict: each inner node takes a node table read, then a feature read and compare;
//   then multiply, round and accumulate before the result goes to the output register;
//   a walk that stops at the depth limit skips the multiply, round and accumulate.
// One request at a time; req.ready is high only while the sequencer is idle.
// A finished result waits in the output register while the next request is taken.
// rst_n clears control state and config registers; tables are undefined until written.
`timescale 1ns / 1ps

module decision_tree_inference #(
    parameter int MAX_DEPTH = dti_pkg::MaxDepth
) (
    input  logic      clk,
    input  logic      rst_n,
    dti_req_if.sink   req,
    dti_rsp_if.source rsp,
    dti_cfg_if.sink   cfg
);

    localparam int StepW   = $clog2(MAX_DEPTH + 1);
    localparam int EntryW  = $bits(dti_pkg::node_entry_t);
    localparam int ProdW   = 2 * dti_pkg::ValW;

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NODE = 3'd1;
    localparam logic [2:0] ST_FEAT = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_RND  = 3'd4;
    localparam logic [2:0] ST_ACC  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [StepW-1:0] steps_reg, steps_next;

    // Configuration registers
    logic [dti_pkg::NodeW-1:0]        root_reg;
    logic signed [dti_pkg::ValW-1:0]  scale_reg;

    // Datapath registers
    logic signed [dti_pkg::SumW-1:0]  prior_reg, prior_next;
    logic signed [dti_pkg::ValW-1:0]  leaf_reg, leaf_next;
    logic signed [ProdW-1:0]          prod_reg, prod_next;
    logic signed [dti_pkg::SumW-1:0]  rnd_reg, rnd_next;

    // Result held for the output register
    logic [dti_pkg::StatW-1:0]        res_status_reg, res_status_next;
    logic signed [dti_pkg::ValW-1:0]  res_leaf_reg, res_leaf_next;
    logic signed [dti_pkg::SumW-1:0]  res_sum_reg, res_sum_next;
    logic [StepW-1:0]                 res_steps_reg, res_steps_next;

    // Output register
    logic                             out_valid_reg, out_valid_next;
    logic [dti_pkg::StatW-1:0]        out_status_reg;
    logic signed [dti_pkg::ValW-1:0]  out_leaf_reg;
    logic signed [dti_pkg::SumW-1:0]  out_sum_reg;
    logic [StepW-1:0]                 out_steps_reg;
    logic                             out_load;
    logic [6:0]                       out_steps_wide;

    // Table ports
    logic                             node_wr_en, node_rd_en;
    logic [dti_pkg::NodeW-1:0]        node_rd_addr;
    logic [EntryW-1:0]                node_rd_data;
    dti_pkg::node_entry_t             node_wr_entry, node_q;
    logic                             feat_wr_en, feat_rd_en;
    logic [dti_pkg::ValW-1:0]         feat_rd_data;

    // Arithmetic
    logic                             req_take;
    logic                             go_left;
    logic signed [ProdW-1:0]          prod_biased;
    logic signed [dti_pkg::SumW:0]    sum_wide;

    assign req_take  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign node_q = dti_pkg::node_entry_t'(node_rd_data);

    // Pack the incoming node entry
    always_comb
    begin
        node_wr_entry.is_leaf   = req.node_is_leaf;
        node_wr_entry.feature   = req.node_feature;
        node_wr_entry.threshold = req.node_threshold;
        node_wr_entry.left      = req.node_left;
        node_wr_entry.right     = req.node_right;
        node_wr_entry.value     = req.node_value;
    end

    assign node_wr_en = req_take && (req.req_type == dti_pkg::ReqNode);
    assign feat_wr_en = req_take && (req.req_type == dti_pkg::ReqFeat);

    dti_ram #(
        .Width (EntryW),
        .Depth (dti_pkg::Nodes)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (node_wr_en),
        .wr_addr (req.node_index),
        .wr_data (EntryW'(node_wr_entry)),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (node_rd_data)
    );

    dti_ram #(
        .Width (dti_pkg::ValW),
        .Depth (dti_pkg::Features)
    ) u_feat_ram (
        .clk     (clk),
        .wr_en   (feat_wr_en),
        .wr_addr (req.feature_index),
        .wr_data (req.feature_value),
        .rd_en   (feat_rd_en),
        .rd_addr (node_q.feature),
        .rd_data (feat_rd_data)
    );

    // Split decision: feature below threshold goes left
    assign go_left = ($signed(feat_rd_data) < node_q.threshold);

    // Round Q32.32 to Q32.16, floor after the half bias
    assign prod_biased = prod_reg + dti_pkg::RoundBias;

    // Accumulate with one guard bit
    assign sum_wide = {prior_reg[dti_pkg::SumW-1], prior_reg}
                    + {rnd_reg[dti_pkg::SumW-1], rnd_reg};

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || rsp.ready);

    // Sequencer and datapath next values
    always_comb
    begin
        state_next      = state_reg;
        steps_next      = steps_reg;
        prior_next      = prior_reg;
        leaf_next       = leaf_reg;
        prod_next       = prod_reg;
        rnd_next        = rnd_reg;
        res_status_next = res_status_reg;
        res_leaf_next   = res_leaf_reg;
        res_sum_next    = res_sum_reg;
        res_steps_next  = res_steps_reg;
        node_rd_en      = 1'b0;
        node_rd_addr    = root_reg;
        feat_rd_en      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    res_status_next = dti_pkg::StatDone;
                    res_leaf_next   = '0;
                    res_sum_next    = '0;
                    res_steps_next  = '0;
                    case (req.req_type)
                        dti_pkg::ReqNode, dti_pkg::ReqFeat:
                        begin
                            state_next = ST_EMIT;
                        end
                        dti_pkg::ReqPredict:
                        begin
                            // Fetch the root entry
                            node_rd_en = 1'b1;
                            prior_next = req.prior_sum;
                            steps_next = '0;
                            state_next = ST_NODE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_NODE:
            begin
                if (node_q.is_leaf)
                begin
                    leaf_next  = node_q.value;
                    state_next = ST_MUL;
                end
                else if (steps_reg >= StepW'(MAX_DEPTH))
                begin
                    // Depth limit: prior passes through unchanged
                    res_status_next = dti_pkg::StatDepth;
                    res_leaf_next   = '0;
                    res_sum_next    = prior_reg;
                    res_steps_next  = steps_reg;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    feat_rd_en = 1'b1;
                    state_next = ST_FEAT;
                end
            end
            ST_FEAT:
            begin
                // Compare and fetch the chosen child
                node_rd_en   = 1'b1;
                node_rd_addr = go_left ? node_q.left : node_q.right;
                steps_next   = steps_reg + 1'b1;
                state_next   = ST_NODE;
            end
            ST_MUL:
            begin
                prod_next  = ProdW'(scale_reg) * ProdW'(leaf_reg);
                state_next = ST_RND;
            end
            ST_RND:
            begin
                rnd_next   = prod_biased[ProdW-1:16];
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                res_status_next = dti_pkg::StatPred;
                res_leaf_next   = leaf_reg;
                res_steps_next  = steps_reg;
                // Saturate on overflow of the 48-bit sum
                if (sum_wide[dti_pkg::SumW] != sum_wide[dti_pkg::SumW-1])
                begin
                    res_sum_next = sum_wide[dti_pkg::SumW] ? dti_pkg::SatMin : dti_pkg::SatMax;
                end
                else
                begin
                    res_sum_next = sum_wide[dti_pkg::SumW-1:0];
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg  <= dti_pkg::RootReset;
            scale_reg <= dti_pkg::ScaleReset;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                dti_pkg::CfgRoot:  root_reg  <= cfg.data[dti_pkg::NodeW-1:0];
                dti_pkg::CfgScale: scale_reg <= cfg.data;
                default:           ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prior_reg      <= prior_next;
        leaf_reg       <= leaf_next;
        prod_reg       <= prod_next;
        rnd_reg        <= rnd_next;
        res_status_reg <= res_status_next;
        res_leaf_reg   <= res_leaf_next;
        res_sum_reg    <= res_sum_next;
        res_steps_reg  <= res_steps_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_leaf_reg   <= res_leaf_reg;
            out_sum_reg    <= res_sum_reg;
            out_steps_reg  <= res_steps_reg;
        end
    end

    // Drive the response channel
    assign out_steps_wide     = 7'(out_steps_reg);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.leaf_result    = out_leaf_reg;
    assign rsp.prediction_sum = out_sum_reg;
    assign rsp.steps_taken    = out_steps_wide[dti_pkg::StepsW-1:0];

    // Walk counter never passes the depth limit
    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= StepW'(MAX_DEPTH))
        else $error("walk step counter beyond depth limit");

    // Write results carry all-zero payload
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == dti_pkg::StatDone |->
            rsp.leaf_result == '0 && rsp.prediction_sum == '0 && rsp.steps_taken == '0)
        else $error("write result with nonzero payload");

    // Depth errors report the full limit and no leaf
    a_depth_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == dti_pkg::StatDepth |->
            rsp.leaf_result == '0 && out_steps_reg == StepW'(MAX_DEPTH))
        else $error("depth limit result malformed");

    // A predict transfer starts the walk
    a_predict_start: assert property (@(posedge clk) disable iff (!rst_n)
        req_take && req.req_type == dti_pkg::ReqPredict |=> state_reg == ST_NODE)
        else $error("predict did not start a walk");

    // A loaded result shows up on the response channel
    a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> rsp.valid && state_reg == ST_IDLE)
        else $error("result lost at emit");

endmodule
